/* src/sparse_polynomial_arith_top_assert.svh */
// assertion macros used by the checker file
// expects clk and rst_n to be visible where a macro is used
`ifndef SPARSE_POLYNOMIAL_ARITH_TOP_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ARITH_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, checked out of reset
`define SPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* src/spa_pkg.sv */
// types and constants for the sparse polynomial arithmetic block
// no dependencies
package spa_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;

    localparam int unsigned EMIT_MAX = 64;

    localparam logic signed [47:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_MIN = 48'shFFFF_8000_0000;
    localparam logic signed [63:0] RND_HALF = 64'sd32768;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] coef;
        logic [9:0]         exponent;
    } spa_in_t;

    typedef struct packed {
        logic signed [31:0] res_coef;
        logic [10:0]        res_exponent;
        logic               last;
        logic               empty_res;
        logic               error;
    } spa_out_t;

    typedef struct packed {
        logic signed [31:0] coef;
        logic [10:0]        exp;
    } term_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } sat_t;

    function automatic sat_t sat48(input logic signed [47:0] v);
        sat_t r;
        r.ovf = 1'b0;
        if (v > SAT_MAX)
        begin
            r.val = 32'sh7FFF_FFFF;
            r.ovf = 1'b1;
        end
        else if (v < SAT_MIN)
        begin
            r.val = 32'sh8000_0000;
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

/* src/sparse_polynomial_arith_top.sv */
// sparse polynomial add / subtract / multiply with a shared merge unit
// depends on spa_pkg
//
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  spa_in_t  (load A, load B, compute, clear)
// res      out  res_valid/res_stall  spa_out_t (one transaction per result term)
// cfg      in   cfg_we               cfg_wdata (op_mode)
//
// loads and clear are handled in idle; the block is busy from compute until the last term leaves
// add/sub: each merge step is S_MRG_FETCH then S_MRG_STEP (accumulator memory read is registered), nA+nB steps at most
// multiply: per row of A, each product is S_ROW_MUL then S_ROW_RND, then merge steps over acc+row
// emission: each result term is S_EMIT_RD, S_EMIT_LD, S_EMIT_HOLD, staying in S_EMIT_HOLD while res_stall is high
// rst_n clears counts, flag and mode; operand and accumulator stores need no clearing
module sparse_polynomial_arith_top #(
    parameter int MAX_TERMS    = 8,
    parameter int RESULT_TERMS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  spa_pkg::spa_in_t  req,
    output logic              res_valid,
    input  logic              res_stall,
    output spa_pkg::spa_out_t res,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata
);
    import spa_pkg::*;

    localparam int MT_CW  = $clog2(MAX_TERMS + 1);
    localparam int MT_IW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int AC_CW  = $clog2(RESULT_TERMS + 1);
    localparam int AC_IW  = $clog2(RESULT_TERMS);
    localparam int XI_W   = (AC_CW > MT_CW) ? AC_CW : MT_CW;
    localparam int MEM_D  = 2 ** (AC_IW + 1);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_ROW_MUL   = 8'b0000_0010,
        S_ROW_RND   = 8'b0000_0100,
        S_MRG_FETCH = 8'b0000_1000,
        S_MRG_STEP  = 8'b0001_0000,
        S_EMIT_RD   = 8'b0010_0000,
        S_EMIT_LD   = 8'b0100_0000,
        S_EMIT_HOLD = 8'b1000_0000
    } state_t;

    state_t             state_reg;
    logic [1:0]         mode_reg;
    logic               err_reg;
    logic               bank_reg;
    logic [MT_CW-1:0]   a_cnt_reg;
    logic [MT_CW-1:0]   b_cnt_reg;
    logic [MT_CW-1:0]   row_cnt_reg;
    logic [MT_CW-1:0]   arow_reg;
    logic [MT_CW-1:0]   yj_reg;
    logic [XI_W-1:0]    xi_reg;
    logic [AC_CW-1:0]   acc_cnt_reg;
    logic [AC_CW-1:0]   n_reg;
    logic [AC_CW-1:0]   k_reg;
    logic signed [63:0] prod_reg;
    logic [10:0]        pexp_reg;
    term_t              rd_reg;
    spa_out_t           res_reg;

    logic signed [31:0] a_coef_reg [MAX_TERMS];
    logic [9:0]         a_exp_reg  [MAX_TERMS];
    logic signed [31:0] b_coef_reg [MAX_TERMS];
    logic [9:0]         b_exp_reg  [MAX_TERMS];
    logic signed [31:0] row_coef_reg [MAX_TERMS];
    logic [10:0]        row_exp_reg  [MAX_TERMS];
    term_t              acc_mem [MEM_D];

    logic               accept;
    logic               mul_mode;
    logic               neg_y;
    logic               load_a_ok;
    logic               load_b_ok;
    logic               load_a_bad;
    logic               load_b_bad;
    logic [MT_CW-1:0]   a_last;
    logic [MT_CW-1:0]   b_last;
    logic [XI_W-1:0]    nx;
    logic [MT_CW-1:0]   ny;
    logic               xv;
    logic               yv;
    logic signed [31:0] x_coef;
    logic [10:0]        x_exp;
    logic signed [31:0] y_coef;
    logic [10:0]        y_exp;
    logic               both;
    logic               take_x;
    logic signed [32:0] merge_v;
    sat_t               merge_s;
    logic [10:0]        merge_e;
    logic               push_ok;
    logic               acc_full;
    logic signed [63:0] rnd;
    sat_t               prod_s;
    logic               row_we;
    logic               mem_we;
    logic [AC_IW:0]     rd_addr;
    logic [AC_IW:0]     wr_addr;
    logic [AC_CW:0]     k_inc;
    logic               emit_last;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_EMIT_HOLD);
    assign res       = res_reg;
    assign mul_mode  = (mode_reg == MODE_MUL);
    assign neg_y     = (mode_reg == MODE_SUB);

    // load checks: zero coefficient is ignored silently, full or non-descending exponent sets the flag
    assign a_last = a_cnt_reg - MT_CW'(1);
    assign b_last = b_cnt_reg - MT_CW'(1);
    assign load_a_bad = (a_cnt_reg == MT_CW'(MAX_TERMS)) ||
                        ((a_cnt_reg != '0) && (req.exponent >= a_exp_reg[a_last[MT_IW-1:0]]));
    assign load_b_bad = (b_cnt_reg == MT_CW'(MAX_TERMS)) ||
                        ((b_cnt_reg != '0) && (req.exponent >= b_exp_reg[b_last[MT_IW-1:0]]));
    assign load_a_ok = accept && (req.req_type == REQ_LOAD_A) && (req.coef != '0) && !load_a_bad;
    assign load_b_ok = accept && (req.req_type == REQ_LOAD_B) && (req.coef != '0) && !load_b_bad;

    // merge operands: x is A or the accumulator, y is B or the product row
    assign nx = mul_mode ? XI_W'(acc_cnt_reg) : XI_W'(a_cnt_reg);
    assign ny = mul_mode ? row_cnt_reg : b_cnt_reg;
    assign xv = (xi_reg < nx);
    assign yv = (yj_reg < ny);

    always_comb
    begin
        if (mul_mode)
        begin
            x_coef = rd_reg.coef;
            x_exp  = rd_reg.exp;
            y_coef = row_coef_reg[yj_reg[MT_IW-1:0]];
            y_exp  = row_exp_reg[yj_reg[MT_IW-1:0]];
        end
        else
        begin
            x_coef = a_coef_reg[xi_reg[MT_IW-1:0]];
            x_exp  = {1'b0, a_exp_reg[xi_reg[MT_IW-1:0]]};
            y_coef = b_coef_reg[yj_reg[MT_IW-1:0]];
            y_exp  = {1'b0, b_exp_reg[yj_reg[MT_IW-1:0]]};
        end
    end

    assign both   = xv && yv && (x_exp == y_exp);
    assign take_x = !both && (!yv || (xv && (x_exp > y_exp)));

    always_comb
    begin
        if (both)
            merge_v = neg_y ? ({x_coef[31], x_coef} - {y_coef[31], y_coef})
                            : ({x_coef[31], x_coef} + {y_coef[31], y_coef});
        else if (take_x)
            merge_v = {x_coef[31], x_coef};
        else
            merge_v = neg_y ? -{y_coef[31], y_coef} : {y_coef[31], y_coef};
    end

    assign merge_s  = sat48({{15{merge_v[32]}}, merge_v});
    assign merge_e  = (both || take_x) ? x_exp : y_exp;
    assign acc_full = (n_reg >= AC_CW'(RESULT_TERMS));
    assign push_ok  = (merge_s.val != '0) && !acc_full;
    assign mem_we   = (state_reg == S_MRG_STEP) && push_ok;

    // product rescale: floor((p + 2^15) / 2^16) is the upper bits of the biased product
    assign rnd    = prod_reg + RND_HALF;
    assign prod_s = sat48(rnd[63:16]);
    assign row_we = (state_reg == S_ROW_RND) && (prod_s.val != '0);

    assign rd_addr = (state_reg == S_EMIT_RD) ? {bank_reg, k_reg[AC_IW-1:0]}
                                              : {bank_reg, xi_reg[AC_IW-1:0]};
    assign wr_addr = {~bank_reg, n_reg[AC_IW-1:0]};

    assign k_inc     = {1'b0, k_reg} + (AC_CW + 1)'(1);
    assign emit_last = (k_inc == {1'b0, acc_cnt_reg}) || (32'(k_inc) == EMIT_MAX);

    // accumulator: two banks, merge reads one and writes the other
    always_ff @(posedge clk)
    begin
        if (mem_we)
            acc_mem[wr_addr] <= '{coef: merge_s.val, exp: merge_e};
        rd_reg <= acc_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load_a_ok)
        begin
            a_coef_reg[a_cnt_reg[MT_IW-1:0]] <= req.coef;
            a_exp_reg[a_cnt_reg[MT_IW-1:0]]  <= req.exponent;
        end
        if (load_b_ok)
        begin
            b_coef_reg[b_cnt_reg[MT_IW-1:0]] <= req.coef;
            b_exp_reg[b_cnt_reg[MT_IW-1:0]]  <= req.exponent;
        end
        if (row_we)
        begin
            row_coef_reg[row_cnt_reg[MT_IW-1:0]] <= prod_s.val;
            row_exp_reg[row_cnt_reg[MT_IW-1:0]]  <= pexp_reg;
        end
        if (state_reg == S_ROW_MUL)
        begin
            prod_reg <= 64'(a_coef_reg[arow_reg[MT_IW-1:0]]) *
                        64'(b_coef_reg[yj_reg[MT_IW-1:0]]);
            pexp_reg <= {1'b0, a_exp_reg[arow_reg[MT_IW-1:0]]} +
                        {1'b0, b_exp_reg[yj_reg[MT_IW-1:0]]};
        end
        if (state_reg == S_EMIT_LD)
        begin
            if (acc_cnt_reg == '0)
                res_reg <= '{res_coef: '0, res_exponent: '0, last: 1'b1,
                             empty_res: 1'b1, error: err_reg};
            else
                res_reg <= '{res_coef: rd_reg.coef, res_exponent: rd_reg.exp,
                             last: emit_last, empty_res: 1'b0, error: err_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_ADD;
            err_reg     <= 1'b0;
            bank_reg    <= 1'b0;
            a_cnt_reg   <= '0;
            b_cnt_reg   <= '0;
            row_cnt_reg <= '0;
            arow_reg    <= '0;
            yj_reg      <= '0;
            xi_reg      <= '0;
            acc_cnt_reg <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.req_type)
                            REQ_LOAD_A:
                            begin
                                if (load_a_ok)
                                    a_cnt_reg <= a_cnt_reg + MT_CW'(1);
                                else if (req.coef != '0)
                                    err_reg <= 1'b1;
                            end
                            REQ_LOAD_B:
                            begin
                                if (load_b_ok)
                                    b_cnt_reg <= b_cnt_reg + MT_CW'(1);
                                else if (req.coef != '0)
                                    err_reg <= 1'b1;
                            end
                            REQ_CLEAR:
                            begin
                                a_cnt_reg   <= '0;
                                b_cnt_reg   <= '0;
                                acc_cnt_reg <= '0;
                                err_reg     <= 1'b0;
                            end
                            default:
                            begin
                                xi_reg      <= '0;
                                yj_reg      <= '0;
                                n_reg       <= '0;
                                k_reg       <= '0;
                                arow_reg    <= '0;
                                row_cnt_reg <= '0;
                                if (mul_mode)
                                begin
                                    acc_cnt_reg <= '0;
                                    // an empty operand gives the zero polynomial
                                    if (a_cnt_reg == '0 || b_cnt_reg == '0)
                                        state_reg <= S_EMIT_RD;
                                    else
                                        state_reg <= S_ROW_MUL;
                                end
                                else
                                begin
                                    state_reg <= S_MRG_FETCH;
                                end
                            end
                        endcase
                    end
                end

                S_ROW_MUL:
                begin
                    state_reg <= S_ROW_RND;
                end

                S_ROW_RND:
                begin
                    if (prod_s.ovf)
                        err_reg <= 1'b1;
                    if (prod_s.val != '0)
                        row_cnt_reg <= row_cnt_reg + MT_CW'(1);
                    if (yj_reg + MT_CW'(1) == b_cnt_reg)
                    begin
                        yj_reg    <= '0;
                        xi_reg    <= '0;
                        n_reg     <= '0;
                        state_reg <= S_MRG_FETCH;
                    end
                    else
                    begin
                        yj_reg    <= yj_reg + MT_CW'(1);
                        state_reg <= S_ROW_MUL;
                    end
                end

                S_MRG_FETCH:
                begin
                    if (!xv && !yv)
                    begin
                        acc_cnt_reg <= n_reg;
                        bank_reg    <= ~bank_reg;
                        k_reg       <= '0;
                        if (mul_mode && (arow_reg + MT_CW'(1) < a_cnt_reg))
                        begin
                            arow_reg    <= arow_reg + MT_CW'(1);
                            yj_reg      <= '0;
                            row_cnt_reg <= '0;
                            state_reg   <= S_ROW_MUL;
                        end
                        else
                        begin
                            state_reg <= S_EMIT_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_MRG_STEP;
                    end
                end

                S_MRG_STEP:
                begin
                    if (merge_s.ovf || ((merge_s.val != '0) && acc_full))
                        err_reg <= 1'b1;
                    if (push_ok)
                        n_reg <= n_reg + AC_CW'(1);
                    if (both || take_x)
                        xi_reg <= xi_reg + XI_W'(1);
                    if (!take_x)
                        yj_reg <= yj_reg + MT_CW'(1);
                    state_reg <= S_MRG_FETCH;
                end

                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end

                S_EMIT_LD:
                begin
                    state_reg <= S_EMIT_HOLD;
                end

                S_EMIT_HOLD:
                begin
                    if (!res_stall)
                    begin
                        if (res_reg.last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + AC_CW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/spa_check.sv */
// port-level checks for the sparse polynomial block, bound to the top level
// depends on spa_pkg and sparse_polynomial_arith_top_assert.svh
`include "sparse_polynomial_arith_top_assert.svh"

module spa_check (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input spa_pkg::spa_in_t  req,
    input logic              res_valid,
    input logic              res_stall,
    input spa_pkg::spa_out_t res,
    input logic              cfg_we,
    input logic [1:0]        cfg_wdata
);
    import spa_pkg::*;

    // a stalled result transaction holds
    `SPA_ASSERT_NXT(res_hold_a, res_valid && res_stall, res_valid && $stable(res))
    // no request is taken while results are going out
    `SPA_ASSERT_IMP(busy_emit_a, res_valid, req_stall)
    // zero polynomial is a single all-zero item
    `SPA_ASSERT_IMP(empty_form_a, res_valid && res.empty_res, res.last && (res.res_coef == '0) && (res.res_exponent == '0))
    // a real result term never has a zero coefficient
    `SPA_ASSERT_IMP(nonzero_a, res_valid && !res.empty_res, res.res_coef != '0)

endmodule

bind sparse_polynomial_arith_top spa_check u_spa_check (.*);
